// ===== rtl/fixed_point_q24_8_alu_assert.svh =====
// assertion macros for the q24.8 alu
// needs clk and rst_n in the scope of each use
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// same-cycle implication
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
// shared types and constants for the q24.8 alu
// no dependencies
`default_nettype none
package fpa_pkg;
  localparam int DEF_INT_BITS  = 24;
  localparam int DEF_FRAC_BITS = 8;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]   kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               div_by_zero;
  } res_t;

  // control that rides along the divider chain
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       neg;
    logic       dz;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/fixed_point_q24_8_alu.sv =====
// q24.8 alu: add, subtract, multiply, divide, results in q48.16
// path: front register, then DW = min(INT_BITS+FRAC_BITS,32)+FRAC_BITS cells of the
// divider chain, then the output register; every kind of request takes this path
// throughput: one request per cycle, busy stays low; the receiver cannot stall
// reset: synchronous active-low rst_n clears all valid bits in the chain
// depends on fpa_pkg, fpa_cell and fixed_point_q24_8_alu_assert.svh
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"
module fixed_point_q24_8_alu
  import fpa_pkg::*;
#(
  parameter int INT_BITS  = DEF_INT_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire req_t in_req,
  output logic      out_valid,
  output res_t      out_res
);
  localparam int OPW = INT_BITS + FRAC_BITS;
  localparam int LW  = (OPW > 32) ? 32 : OPW;
  localparam int DW  = LW + FRAC_BITS;

  logic          acc;
  logic [63:0]   a64, b64, sum64, dif64, fast;
  logic [LW-1:0] al, bl, ma, mb;
  logic [2*LW-1:0] prod;
  cell_ctl_t     ctl0;

  cell_ctl_t     ctl_w  [0:DW];
  logic [63:0]   fast_w [0:DW];
  logic [LW-1:0] rem_w  [0:DW];
  logic [DW-1:0] dvd_w  [0:DW];
  logic [LW-1:0] dvs_w  [0:DW];

  cell_ctl_t     ctl_r;
  logic [63:0]   fast_r;
  logic [DW-1:0] dvd_r;
  logic [LW-1:0] dvs_r;

  logic [63:0]   qx, qs, res_nxt;
  logic          out_valid_r;
  res_t          out_res_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_comb begin
    al    = in_req.operand_a[LW-1:0];
    bl    = in_req.operand_b[LW-1:0];
    a64   = 64'(signed'(al));
    b64   = 64'(signed'(bl));
    sum64 = a64 + b64;
    dif64 = a64 - b64;
    prod  = signed'(al) * signed'(bl);
    ma    = al[LW-1] ? (~al + 1'b1) : al;
    mb    = bl[LW-1] ? (~bl + 1'b1) : bl;
    case (in_req.kind)
      KIND_ADD: fast = 64'(signed'(sum64[OPW-1:0])) << FRAC_BITS;
      KIND_SUB: fast = 64'(signed'(dif64[OPW-1:0])) << FRAC_BITS;
      KIND_MUL: fast = 64'(signed'(prod));
      default:  fast = '0;
    endcase
    ctl0.valid = acc;
    ctl0.kind  = in_req.kind;
    ctl0.neg   = al[LW-1] ^ bl[LW-1];
    ctl0.dz    = (in_req.kind == KIND_DIV) && (mb == '0);
  end

  // front register: operands decoded, multiply done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl0;
    end
    fast_r <= fast;
    dvd_r  <= {ma, {FRAC_BITS{1'b0}}};
    dvs_r  <= mb;
  end

  assign ctl_w[0]  = ctl_r;
  assign fast_w[0] = fast_r;
  assign rem_w[0]  = '0;
  assign dvd_w[0]  = dvd_r;
  assign dvs_w[0]  = dvs_r;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_cell #(.LW(LW), .DW(DW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_w[i]),
      .fast_i (fast_w[i]),
      .rem_i  (rem_w[i]),
      .dvd_i  (dvd_w[i]),
      .dvs_i  (dvs_w[i]),
      .ctl_o  (ctl_w[i+1]),
      .fast_o (fast_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .dvd_o  (dvd_w[i+1]),
      .dvs_o  (dvs_w[i+1])
    );
  end

  always_comb begin
    qx = 64'(dvd_w[DW]);
    qs = ctl_w[DW].neg ? (~qx + 64'd1) : qx;
    if (ctl_w[DW].kind != KIND_DIV) begin
      res_nxt = fast_w[DW];
    end else if (ctl_w[DW].dz) begin
      res_nxt = '0;
    end else begin
      res_nxt = qs << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_w[DW].valid;
    end
    out_res_r.result      <= res_nxt;
    out_res_r.div_by_zero <= ctl_w[DW].dz;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `FPA_ASSERT_IMP(a_dz_zero, out_valid && out_res.div_by_zero, out_res.result == 64'd0,
                  "divide by zero with nonzero result")
  `FPA_ASSERT_NXT(a_dz_kind, ctl_w[DW].valid && ctl_w[DW].dz,
                  out_valid && out_res.div_by_zero, "zero-divisor flag lost at output")
  `FPA_ASSERT_IMP(a_latency, acc, ##(DW+2) out_valid, "result missing after request")
  `FPA_ASSERT_NXT(a_no_ghost, !ctl_w[DW].valid, !out_valid, "result without request")
endmodule
`default_nettype wire

// ===== rtl/fpa_cell.sv =====
// one restoring-division step of the divider chain, registered
// depends on fpa_pkg
`default_nettype none
module fpa_cell
  import fpa_pkg::*;
#(
  parameter int LW = 32,
  parameter int DW = 40
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cell_ctl_t     ctl_i,
  input  wire logic [63:0]   fast_i,
  input  wire logic [LW-1:0] rem_i,
  input  wire logic [DW-1:0] dvd_i,
  input  wire logic [LW-1:0] dvs_i,
  output cell_ctl_t          ctl_o,
  output logic [63:0]        fast_o,
  output logic [LW-1:0]      rem_o,
  output logic [DW-1:0]      dvd_o,
  output logic [LW-1:0]      dvs_o
);
  cell_ctl_t     ctl_r;
  logic [63:0]   fast_r;
  logic [LW-1:0] rem_r, rem_nxt, dvs_r;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [LW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial   = {rem_i, dvd_i[DW-1]};
    diff    = trial - {1'b0, dvs_i};
    ge      = (trial >= {1'b0, dvs_i});
    rem_nxt = ge ? diff[LW-1:0] : trial[LW-1:0];
    // quotient bit enters where the dividend bit left
    dvd_nxt = {dvd_i[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    fast_r <= fast_i;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_i;
  end

  assign ctl_o  = ctl_r;
  assign fast_o = fast_r;
  assign rem_o  = rem_r;
  assign dvd_o  = dvd_r;
  assign dvs_o  = dvs_r;
endmodule
`default_nettype wire
